FILE: src/ltfe_pkg.sv
`default_nettype none
package ltfe_pkg;

   // Default strip length and phase width.
   localparam int LED_COUNT_DEFAULT = 512;
   localparam int PHASE_W = 8;
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 9;

   // Phase schedule of one twinkle.
   localparam logic [PHASE_W-1:0] PHASE_IDLE  = 8'd0;
   localparam logic [PHASE_W-1:0] PHASE_START = 8'd1;
   localparam logic [PHASE_W-1:0] PHASE_PEAK  = 8'd128;
   localparam logic [PHASE_W-1:0] PHASE_END   = 8'd254;
   localparam logic [PHASE_W-1:0] STEP_IN     = 8'd4;
   localparam logic [PHASE_W-1:0] STEP_OUT    = 8'd2;
   localparam logic [COLOR_W-1:0] BRI_MAX     = 8'd255;

   // Spawn chance range and the reset values of the registers.
   localparam logic [7:0] CHANCE_MIN   = 8'd5;
   localparam logic [7:0] CHANCE_SPAN  = 8'd35;
   localparam logic [7:0] SPEED_RESET  = 8'd128;
   localparam logic [7:0] COLOR_RESET  = 8'd255;

   // Register map, one register per 32-bit word.
   typedef enum logic [1:0] {
      REG_SPAWN_SPEED = 2'd0,
      REG_COLOR_RED   = 2'd1,
      REG_COLOR_GREEN = 2'd2,
      REG_COLOR_BLUE  = 2'd3
   } csr_reg_type;

   // Outcome of one phase update.
   typedef struct packed {
      logic               lit;
      logic [COLOR_W-1:0] bri;
      logic [PHASE_W-1:0] phase;
   } phase_step_type;

endpackage
`default_nettype wire

FILE: src/led_twinkle_fade_engine_unit.sv
`default_nettype none
// LED twinkle fade engine.
// Each item on the req_ channel names one LED (index, random byte, and a
// first-frame flag in req_tuser). The block returns one item per request on
// the rsp_ channel holding the LED index and its red, green and blue values.
// Every LED has an 8-bit fade phase in a single-port-write RAM; an item reads
// its entry, updates it, and writes it back. A back-to-back item on the same
// LED takes the updated phase from a forwarding register.
// Throughput: one item per clock cycle while rsp_tready is high and no clearing
// pass runs. A result goes through RAM read, phase update and color scale.
// The three pipeline stages stall separately, so requests keep flowing into
// empty stages while a result waits on rsp_tready.
// Reset: the phase RAM is cleared one entry per cycle and req_tready stays low
// during that pass. Registers return to speed 128 and white. The user writes
// them via the csr_ port only while no item is in flight; the block has no guard.
module led_twinkle_fade_engine_unit #(
   parameter int LED_COUNT = ltfe_pkg::LED_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // led_index[8:0], random_byte[16:9], zero pad
   input  wire logic [23:0] req_tdata,
   // first_frame[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_index[8:0], out_red[16:9], out_green[24:17], out_blue[32:25], zero pad
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ltfe_pkg::*;

   localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CountW = $clog2(4097);

   // Spawn chance 5..40 from the speed setting, dividing by 254 through a
   // reciprocal multiply with one correction step.
   function automatic logic [7:0] chance_of(input logic [7:0] speed);
      logic [13:0] num;
      logic [21:0] prod;
      logic [5:0]  quo;
      logic [13:0] rem;
      num  = 14'(speed - 8'd1) * 14'(CHANCE_SPAN);
      prod = 22'(num) * 22'd258;
      quo  = prod[21:16];
      rem  = num - 14'(quo) * 14'd254;
      if (rem >= 14'd254) begin
         quo = quo + 6'd1;
      end
      if (speed == 8'd0) begin
         chance_of = CHANCE_MIN;
      end else begin
         chance_of = 8'(quo) + CHANCE_MIN;
      end
   endfunction

   // Configuration registers.
   logic [7:0]  speed_ff, red_ff, green_ff, blue_ff, chance_ff;
   logic        csr_write;
   csr_reg_type csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_RESET;
         chance_ff <= chance_of(SPEED_RESET);
         red_ff    <= COLOR_RESET;
         green_ff  <= COLOR_RESET;
         blue_ff   <= COLOR_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_SPAWN_SPEED: begin
               speed_ff  <= csr_pwdata[7:0];
               chance_ff <= chance_of(csr_pwdata[7:0]);
            end
            REG_COLOR_RED:   red_ff   <= csr_pwdata[7:0];
            REG_COLOR_GREEN: green_ff <= csr_pwdata[7:0];
            REG_COLOR_BLUE:  blue_ff  <= csr_pwdata[7:0];
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_sel)
         REG_SPAWN_SPEED: csr_prdata = 32'(speed_ff);
         REG_COLOR_RED:   csr_prdata = 32'(red_ff);
         REG_COLOR_GREEN: csr_prdata = 32'(green_ff);
         REG_COLOR_BLUE:  csr_prdata = 32'(blue_ff);
      endcase
   end

   // Clearing pass over the phase RAM after reset.
   logic             clr_active_ff;
   logic [AddrW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AddrW'(LED_COUNT - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Request fields.
   logic [INDEX_W-1:0] req_index;
   logic [7:0]         req_random;
   logic               req_first;
   logic               req_in_range;
   logic               accept;

   assign req_index    = req_tdata[8:0];
   assign req_random   = req_tdata[16:9];
   assign req_first    = req_tuser[0];
   assign req_in_range = CountW'(req_index) < CountW'(LED_COUNT);

   // Stage handshakes: each stage moves when the next one is empty or moving.
   logic s1_valid_ff, s2_valid_ff;
   logic en1, en2, out_ready;

   assign en2        = !s2_valid_ff || out_ready;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1 && !clr_active_ff;
   assign accept     = req_tvalid && req_tready;

   // Stage 1: the RAM read is in flight, then the phase is updated.
   logic [INDEX_W-1:0] s1_index_ff;
   logic [7:0]         s1_random_ff;
   logic               s1_first_ff;
   logic               s1_in_range_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [PHASE_W-1:0] fwd_phase_ff;
   logic [PHASE_W-1:0] ram_rd_data;
   logic [PHASE_W-1:0] phase_old;
   logic               s1_write;
   phase_step_type     step;

   // The item in stage 1 writes back at the edge it leaves; a request for
   // the same LED accepted at that edge takes the new phase from here.
   assign s1_write   = s1_valid_ff && s1_in_range_ff && en2;
   assign fwd_hit_in = accept && s1_write && (s1_index_ff == req_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= accept;
         fwd_hit_ff  <= fwd_hit_in;
      end
      if (accept) begin
         s1_index_ff    <= req_index;
         s1_random_ff   <= req_random;
         s1_first_ff    <= req_first;
         s1_in_range_ff <= req_in_range;
         fwd_phase_ff   <= step.phase;
      end
   end

   always_comb begin
      if (s1_first_ff) begin
         phase_old = PHASE_IDLE;
      end else if (fwd_hit_ff) begin
         phase_old = fwd_phase_ff;
      end else begin
         phase_old = ram_rd_data;
      end
   end

   ltfe_phase_step u_step (
      .phase_old    (phase_old),
      .random_byte  (s1_random_ff),
      .spawn_chance (chance_ff),
      .step         (step)
   );

   // Phase RAM; the clearing pass owns the write port while it runs.
   ltfe_ram #(
      .WIDTH (PHASE_W),
      .DEPTH (LED_COUNT)
   ) u_phase_ram (
      .clock   (clock),
      .wr_en   (clr_active_ff || s1_write),
      .wr_addr (clr_active_ff ? clr_addr_ff : AddrW'(s1_index_ff)),
      .wr_data (clr_active_ff ? PHASE_IDLE : step.phase),
      .rd_en   (accept),
      .rd_addr (AddrW'(req_index)),
      .rd_data (ram_rd_data)
   );

   // Stage 2: brightness waits for the color multipliers.
   logic [INDEX_W-1:0] s2_index_ff;
   logic               s2_lit_ff;
   logic [COLOR_W-1:0] s2_bri_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en2 && s1_valid_ff) begin
         s2_index_ff <= s1_index_ff;
         s2_lit_ff   <= step.lit && s1_in_range_ff;
         s2_bri_ff   <= step.bri;
      end
   end

   ltfe_color_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid_ff),
      .in_ready    (out_ready),
      .in_index    (s2_index_ff),
      .in_lit      (s2_lit_ff),
      .in_bri      (s2_bri_ff),
      .color_red   (red_ff),
      .color_green (green_ff),
      .color_blue  (blue_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // The clearing pass ends only after the last entry has been written.
   assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> $past(clr_addr_ff) == AddrW'(LED_COUNT - 1))
      else $error("clearing pass ended early");

   // No item is in stage 1 or stage 2 while the clearing pass owns the RAM.
   assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("item in flight during clearing pass");

   // A forwarded phase only ever belongs to a live stage-1 item.
   assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff && !s1_first_ff || s1_valid_ff)
      else $error("stale forwarding hit");

endmodule
`default_nettype wire

FILE: src/ltfe_ram.sv
`default_nettype none
module ltfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port; a read at the written address returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/ltfe_phase_step.sv
`default_nettype none
module ltfe_phase_step (
   input  wire logic [7:0]               phase_old,
   input  wire logic [7:0]               random_byte,
   input  wire logic [7:0]               spawn_chance,
   output ltfe_pkg::phase_step_type      step
);
   import ltfe_pkg::*;

   logic [PHASE_W-1:0] rise;
   logic [PHASE_W-1:0] fall;
   logic [PHASE_W-1:0] fall_gap;

   assign rise     = phase_old + STEP_IN;
   assign fall     = phase_old + STEP_OUT;
   assign fall_gap = BRI_MAX - fall;

   // Idle LEDs may start, rising LEDs brighten to the peak, falling LEDs dim out.
   always_comb begin
      step = '0;
      priority if (phase_old == PHASE_IDLE) begin
         step.phase = (random_byte < spawn_chance) ? PHASE_START : PHASE_IDLE;
      end else if (phase_old < PHASE_PEAK) begin
         step.lit = 1'b1;
         if (rise >= PHASE_PEAK) begin
            step.phase = PHASE_PEAK;
            step.bri   = BRI_MAX;
         end else begin
            step.phase = rise;
            step.bri   = {rise[PHASE_W-2:0], 1'b0};
         end
      end else begin
         step.lit   = 1'b1;
         step.bri   = {fall_gap[PHASE_W-2:0], 1'b0};
         step.phase = (fall >= PHASE_END) ? PHASE_IDLE : fall;
      end
   end

endmodule
`default_nettype wire

FILE: src/ltfe_color_out.sv
`default_nettype none
module ltfe_color_out (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [8:0]  in_index,
   input  wire logic        in_lit,
   input  wire logic [7:0]  in_bri,
   input  wire logic [7:0]  color_red,
   input  wire logic [7:0]  color_green,
   input  wire logic [7:0]  color_blue,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_index[8:0], out_red[16:9], out_green[24:17], out_blue[32:25], zero pad
   output logic [39:0]      rsp_tdata
);
   import ltfe_pkg::*;

   logic              valid_ff;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [COLOR_W-1:0] red_ff, red_in;
   logic [COLOR_W-1:0] green_ff, green_in;
   logic [COLOR_W-1:0] blue_ff, blue_in;
   logic [15:0]       gain;
   logic [15:0]       prod_red, prod_green, prod_blue;

   assign in_ready = !valid_ff || rsp_tready;

   // Scale each channel by (brightness + 1) / 256; dark LEDs give zero.
   assign gain       = 16'({1'b0, in_bri}) + 16'd1;
   assign prod_red   = 16'(color_red) * gain;
   assign prod_green = 16'(color_green) * gain;
   assign prod_blue  = 16'(color_blue) * gain;

   always_comb begin
      index_in = in_index;
      red_in   = in_lit ? prod_red[15:8] : '0;
      green_in = in_lit ? prod_green[15:8] : '0;
      blue_in  = in_lit ? prod_blue[15:8] : '0;
   end

   // Output register; it loads whenever the current item leaves or it is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         index_ff <= index_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, blue_ff, green_ff, red_ff, index_ff};

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
   import ltfe_pkg::*;

   localparam int LEDS        = LED_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 205;
   localparam int PRINT_LIMIT = 20;
   localparam int DIR_ROWS    = 27;

   // One LED color as it travels on the result channel.
   typedef struct packed {
      logic [8:0] led_id;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } led_color_type;

   // Directed stimulus: either an item or a register write.
   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CFG  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      csr_reg_type  reg_sel;
      logic [7:0]   value;
      logic [8:0]   led;
      logic [7:0]   rnd;
      logic         first;
      logic         typed;
      logic [23:0]  want_rgb;  // blue, green, red from the top down
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // led_index[8:0], random_byte[16:9], zero pad
   logic [0:0]  req_tuser = '0;   // first_frame[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // index[8:0], red[16:9], green[24:17], blue[32:25]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: one fade phase per LED and a copy of the registers.
   logic [7:0]    fade_phase [LEDS];
   logic [7:0]    led_cfg [4];
   led_color_type expected_colors [$];

   int idle_pct = 36;
   int cycle_count = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int lit_results = 0;
   int peak_hits = 0;
   int twinkle_ends = 0;
   int csr_writes = 0;

   led_color_type got_color;
   led_color_type want_color;

   // Directed rows. The spawn chance is 22 at reset, 5 at speeds 0 and 1, 40 at 255.
   stim_row_type stim_rows [DIR_ROWS] = '{
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd255, 1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd21,  1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd1,   8'd22,  1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd255, 1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd0,   1'b1, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_CFG,  REG_SPAWN_SPEED, 8'd0,   9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd2,   8'd4,   1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd3,   8'd5,   1'b0, 1'b1, 24'h0},
      '{ROW_CFG,  REG_SPAWN_SPEED, 8'd255, 9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd4,   8'd39,  1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd5,   8'd40,  1'b0, 1'b1, 24'h0},
      '{ROW_CFG,  REG_SPAWN_SPEED, 8'd1,   9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd6,   8'd4,   1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd7,   8'd5,   1'b0, 1'b1, 24'h0},
      '{ROW_CFG,  REG_COLOR_RED,   8'd0,   9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_CFG,  REG_COLOR_GREEN, 8'd128, 9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_CFG,  REG_COLOR_BLUE,  8'd255, 9'd0,   8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd2,   8'd255, 1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd4,   8'd255, 1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd6,   8'd255, 1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd511, 8'd0,   1'b1, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd511, 8'd0,   1'b0, 1'b0, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd256, 8'd255, 1'b1, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd170, 8'd255, 1'b0, 1'b1, 24'h0},
      '{ROW_ITEM, REG_SPAWN_SPEED, 8'd0,   9'd341, 8'd0,   1'b1, 1'b1, 24'h0}
   };

   led_twinkle_fade_engine_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Speed 0 gives the same chance as speed 1.
   function automatic logic [7:0] spawn_threshold(input logic [7:0] speed);
      int s;
      s = speed;
      if (s == 0) begin
         return CHANCE_MIN;
      end
      return 8'((s - 1) * CHANCE_SPAN / 254 + CHANCE_MIN);
   endfunction

   function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] bri);
      logic [15:0] prod;
      prod = c * (bri + 9'd1);
      return prod[15:8];
   endfunction

   // Advances one LED by one frame and returns the color it shows.
   function automatic led_color_type advance_twinkle(input logic [8:0] idx,
                                                     input logic [7:0] rnd,
                                                     input logic first);
      led_color_type res;
      logic [7:0] p;
      logic [7:0] bri;
      logic       lit;
      res = '0;
      res.led_id = idx;
      bri = '0;
      lit = 1'b0;
      if (idx >= LEDS) begin
         return res;
      end
      p = first ? PHASE_IDLE : fade_phase[idx];
      if (p == PHASE_IDLE) begin
         if (rnd < spawn_threshold(led_cfg[REG_SPAWN_SPEED])) begin
            p = PHASE_START;
         end
      end else if (p < PHASE_PEAK) begin
         // Fade in; the peak saturates instead of wrapping to dark.
         p = p + STEP_IN;
         if (p >= PHASE_PEAK) begin
            p = PHASE_PEAK;
            peak_hits++;
         end
         bri = (p == PHASE_PEAK) ? BRI_MAX : 8'(p * 2);
         lit = 1'b1;
      end else begin
         // Fade out until the end phase, then back to idle.
         p = p + STEP_OUT;
         bri = 8'((BRI_MAX - p) << 1);
         lit = 1'b1;
         if (p >= PHASE_END) begin
            p = PHASE_IDLE;
            twinkle_ends++;
         end
      end
      fade_phase[idx] = p;
      if (lit) begin
         res.red   = dim_channel(led_cfg[REG_COLOR_RED], bri);
         res.green = dim_channel(led_cfg[REG_COLOR_GREEN], bri);
         res.blue  = dim_channel(led_cfg[REG_COLOR_BLUE], bri);
         lit_results++;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int tag, input int got_v,
                                  input int want_v);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch: %s (%0d): got %0d, want %0d", what, tag, got_v, want_v);
      end
   endtask

   // Offers one item after a random gap and records its expected color.
   task automatic send_item(input logic [8:0] idx, input logic [7:0] rnd, input logic first,
                            input logic typed, input logic [23:0] typed_rgb);
      led_color_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, rnd, idx};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      predicted = advance_twinkle(idx, rnd, first);
      if (typed) begin
         predicted = {idx, typed_rgb[7:0], typed_rgb[15:8], typed_rgb[23:16]};
      end
      expected_colors.push_back(predicted);
      items_sent++;
   endtask

   // Holds the sender off until every expected item has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_colors.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // Writes one register, then reads it back.
   task automatic csr_write(input csr_reg_type sel, input logic [7:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {24'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      led_cfg[sel] = v;
      csr_writes++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== v) begin
         report_mismatch("register readback", int'(sel), csr_prdata[7:0], v);
      end
      // The bus goes idle after the readback.
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic: short strips swept frame by frame, with some stray items.
   task automatic run_phase(input int quota);
      int sent;
      int n;
      int frames;
      int f;
      int k;
      logic [8:0] strip [4];
      logic [7:0] rnd;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
         end else begin
            n = $urandom_range(1, 4);
            frames = $urandom_range(20, 160);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 7) == 0) begin
                  strip[k] = ($urandom_range(0, 1) != 0) ? 9'd511 : 9'd0;
               end else begin
                  strip[k] = 9'($urandom_range(0, 511));
               end
            end
            for (f = 0; f < frames && sent < quota; f++) begin
               for (k = 0; k < n && sent < quota; k++) begin
                  rnd = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 63))
                                                    : 8'($urandom_range(0, 255));
                  send_item(strip[k], rnd, (f == 0) && ($urandom_range(0, 1) != 0),
                            1'b0, '0);
                  sent++;
               end
            end
         end
      end
   endtask

   // Result side: random stalls, and each item checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_color = {rsp_tdata[8:0], rsp_tdata[16:9], rsp_tdata[24:17], rsp_tdata[32:25]};
         results_seen++;
         if (expected_colors.size() == 0) begin
            report_mismatch("item with nothing expected", got_color.led_id, got_color, 0);
         end else begin
            want_color = expected_colors.pop_front();
            if (got_color.led_id !== want_color.led_id) begin
               report_mismatch("out_index", want_color.led_id, got_color.led_id,
                               want_color.led_id);
            end
            if (got_color.red !== want_color.red) begin
               report_mismatch("out_red", want_color.led_id, got_color.red, want_color.red);
            end
            if (got_color.green !== want_color.green) begin
               report_mismatch("out_green", want_color.led_id, got_color.green,
                               want_color.green);
            end
            if (got_color.blue !== want_color.blue) begin
               report_mismatch("out_blue", want_color.led_id, got_color.blue,
                               want_color.blue);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int i;
      int ph;
      logic [7:0] speed_v;
      logic [7:0] red_v;
      logic [7:0] green_v;
      logic [7:0] blue_v;

      for (i = 0; i < LEDS; i++) begin
         fade_phase[i] = PHASE_IDLE;
      end
      led_cfg[REG_SPAWN_SPEED] = SPEED_RESET;
      led_cfg[REG_COLOR_RED]   = COLOR_RESET;
      led_cfg[REG_COLOR_GREEN] = COLOR_RESET;
      led_cfg[REG_COLOR_BLUE]  = COLOR_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      for (i = 0; i < DIR_ROWS; i++) begin
         if (stim_rows[i].kind == ROW_CFG) begin
            wait_drained();
            csr_write(stim_rows[i].reg_sel, stim_rows[i].value);
         end else begin
            send_item(stim_rows[i].led, stim_rows[i].rnd, stim_rows[i].first,
                      stim_rows[i].typed, stim_rows[i].want_rgb);
         end
      end

      // Random part, one register setting per phase, extremes included.
      for (ph = 0; ph < 7; ph++) begin
         speed_v = 8'($urandom_range(0, 255));
         red_v   = 8'($urandom_range(0, 255));
         green_v = 8'($urandom_range(0, 255));
         blue_v  = 8'($urandom_range(0, 255));
         case (ph)
            0: begin
               speed_v = 8'd255; red_v = 8'd255; green_v = 8'd0; blue_v = 8'd128;
            end
            1: begin
               speed_v = 8'd0;
            end
            2: begin
               speed_v = 8'($urandom_range(1, 255));
            end
            3: begin
               speed_v = 8'd1; red_v = 8'd0; green_v = 8'd0; blue_v = 8'd0;
            end
            5: begin
               speed_v = 8'd255; red_v = 8'd255; green_v = 8'd255; blue_v = 8'd255;
            end
            6: begin
               speed_v = 8'd128; red_v = 8'd1; green_v = 8'd254; blue_v = 8'd17;
            end
            default: begin
            end
         endcase
         wait_drained();
         csr_write(REG_SPAWN_SPEED, speed_v);
         csr_write(REG_COLOR_RED, red_v);
         csr_write(REG_COLOR_GREEN, green_v);
         csr_write(REG_COLOR_BLUE, blue_v);
         // One phase runs with both sides busy every cycle.
         idle_pct = (ph == 2) ? 0 : 36;
         run_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d items and %0d results (%0d lit) over %0d register writes",
               items_sent, results_seen, lit_results, csr_writes);
      $display("%0d twinkles reached the peak, %0d faded back to idle, %0d mismatches",
               peak_hits, twinkle_ends, mismatch_count);
      if (mismatch_count == 0 && expected_colors.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
